FILE: hdl/agas_pkg.sv
// Shared types and constants for the analogue gain AE stepper.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package agas_pkg;

   // Field widths fixed by the item formats
   localparam int unsigned DEFAULT_GAIN_BITS = 16;
   localparam int unsigned RESPONSE_BITS     = 2;
   localparam int unsigned SKEW_BITS         = 16;
   localparam int unsigned DECISION_BITS     = 8;
   localparam int unsigned STEP_BITS         = 4;
   localparam int unsigned CSR_INDEX_BITS    = 2;

   // Skewness thresholds for the step size
   localparam logic [SKEW_BITS-1:0] SKEW_STEP8 = 16'd1024;
   localparam logic [SKEW_BITS-1:0] SKEW_STEP4 = 16'd512;
   localparam logic [SKEW_BITS-1:0] SKEW_STEP2 = 16'd256;

   localparam logic [STEP_BITS-1:0] STEP_8 = 4'd8;
   localparam logic [STEP_BITS-1:0] STEP_4 = 4'd4;
   localparam logic [STEP_BITS-1:0] STEP_2 = 4'd2;
   localparam logic [STEP_BITS-1:0] STEP_1 = 4'd1;

   localparam logic [DECISION_BITS-1:0] DECISION_RESET = 8'd1;

   typedef enum logic [RESPONSE_BITS-1:0] {
      VERDICT_NORMAL = 2'd0,
      VERDICT_OVER   = 2'd1,
      VERDICT_HOLD   = 2'd2,
      VERDICT_UNDER  = 2'd3
   } verdict_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIN_GAIN        = 2'd0,
      CSR_MAX_GAIN        = 2'd1,
      CSR_INITIAL_GAIN    = 2'd2,
      CSR_DECISION_FRAMES = 2'd3
   } csr_index_type;

   // Step size picked from skewness magnitude
   function automatic logic [STEP_BITS-1:0] step_size(input logic [SKEW_BITS-1:0] skew);
      logic [STEP_BITS-1:0] step;
      step = STEP_1;
      if (skew > SKEW_STEP8) begin
         step = STEP_8;
      end else if (skew > SKEW_STEP4) begin
         step = STEP_4;
      end else if (skew > SKEW_STEP2) begin
         step = STEP_2;
      end
      return step;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/agas_if.sv
// Valid/ready channel interfaces for the AE stepper: exposure verdict items
// in, gain result items out. Depends on agas_pkg.
`default_nettype none

interface agas_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   ae_valid;
   logic [agas_pkg::RESPONSE_BITS-1:0]     ae_verdict;
   logic [agas_pkg::SKEW_BITS-1:0]         ae_skew;

   modport source (output valid, ae_valid, ae_verdict, ae_skew, input ready);
   modport sink   (input valid, ae_valid, ae_verdict, ae_skew, output ready);
endinterface

interface agas_rsp_if #(
   parameter int unsigned GAIN_BITS = agas_pkg::DEFAULT_GAIN_BITS
);
   logic                 valid;
   logic                 ready;
   logic                 gain_changed;
   logic [GAIN_BITS-1:0] sensor_gain;

   modport source (output valid, gain_changed, sensor_gain, input ready);
   modport sink   (input valid, gain_changed, sensor_gain, output ready);
endinterface

`default_nettype wire

FILE: hdl/analogue_gain_ae_stepper_unit.sv
// Top level of the analogue gain auto-exposure step controller.
// Depends on agas_pkg and the channel interfaces in agas_if.sv.
// Usage:
//  - req_ch carries one exposure verdict item per frame: ae_valid, ae_verdict
//    (normal / over / hold / under) and ae_skew. An item is taken at a
//    clock edge with valid and ready both high.
//  - rsp_ch returns exactly one item per request: gain_changed and the
//    sensor_gain after that frame's decision.
//  - csr_* is a plain write port: min gain, max gain, initial gain and
//    decision length at indexes 0..3. Writing the initial gain loads the
//    clamped value into the current gain. Write only while the block is idle.
//  - The verdict, the run counter and the gain state feed one short block of
//    compare/add logic that is captured in the result register, so the result
//    appears in the cycle after the item is taken. Throughput is one item per clock while the receiver takes results.
//  - When the receiver stalls, the result register holds its item; ready
//    stays high if the result is taken in the same cycle, so a new item can
//    enter while the old one leaves.
//  - reset (synchronous, active high) restores register defaults (min 0,
//    max all ones, decision length 1), gain 0, verdict normal,
//    run count 0, and empties the result register.
`default_nettype none

module analogue_gain_ae_stepper_unit #(
   parameter int unsigned GAIN_BITS = agas_pkg::DEFAULT_GAIN_BITS
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   agas_req_if.sink                                     req_ch,
   agas_rsp_if.source                                   rsp_ch,
   input  wire logic                                    csr_wr_en,
   input  wire logic [agas_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [((GAIN_BITS > agas_pkg::DECISION_BITS) ?
                       GAIN_BITS : agas_pkg::DECISION_BITS)-1:0] csr_wr_data
);

   localparam int unsigned DB = agas_pkg::DECISION_BITS;

   // configuration registers
   logic [GAIN_BITS-1:0] min_gain_ff;
   logic [GAIN_BITS-1:0] max_gain_ff;
   logic [DB-1:0]        decision_ff;

   // controller state
   logic [GAIN_BITS-1:0]  gain_ff,    gain_in;
   agas_pkg::verdict_type verdict_ff, verdict_in;
   logic [DB-1:0]         run_ff,     run_in;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_changed_ff, rsp_changed_in;
   logic [GAIN_BITS-1:0] rsp_gain_ff;

   logic                  accept;
   agas_pkg::verdict_type verdict;
   logic [GAIN_BITS-1:0]  eff_max;
   logic [GAIN_BITS-1:0]  wr_gain;
   logic [GAIN_BITS-1:0]  wr_clamped;
   logic [DB-1:0]         need;
   logic [DB-1:0]         run_next;
   logic [GAIN_BITS-1:0]  step;
   logic [GAIN_BITS-1:0]  room;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign verdict      = agas_pkg::verdict_type'(req_ch.ae_verdict);

   assign eff_max    = (max_gain_ff > min_gain_ff) ? max_gain_ff : min_gain_ff;
   assign wr_gain    = csr_wr_data[GAIN_BITS-1:0];
   assign wr_clamped = (wr_gain < min_gain_ff) ? min_gain_ff :
                       (wr_gain > eff_max)     ? eff_max     : wr_gain;
   assign need       = (decision_ff == '0) ? {{(DB-1){1'b0}}, 1'b1} : decision_ff;
   assign step       = GAIN_BITS'(agas_pkg::step_size(req_ch.ae_skew));

   // per-frame decision
   always_comb begin
      gain_in    = gain_ff;
      verdict_in = verdict_ff;
      run_in     = run_ff;
      run_next   = run_ff;
      room       = '0;
      if (req_ch.ae_valid) begin
         if (verdict != verdict_ff) begin
            verdict_in = verdict;
            run_next   = {{(DB-1){1'b0}}, 1'b1};
         end else if (run_ff != '1) begin
            run_next = run_ff + 1'b1;
         end
         run_in = run_next;
         case (verdict)
            agas_pkg::VERDICT_UNDER: begin
               if (run_next >= need) begin
                  run_in = '0;
                  if (gain_ff < eff_max) begin
                     room    = eff_max - gain_ff;
                     gain_in = gain_ff + ((step < room) ? step : room);
                  end
               end
            end
            agas_pkg::VERDICT_OVER: begin
               if (run_next >= need) begin
                  run_in = '0;
                  if (gain_ff > min_gain_ff) begin
                     room    = gain_ff - min_gain_ff;
                     gain_in = gain_ff - ((step < room) ? step : room);
                  end
               end
            end
            default: begin
               // normal or hold: run is broken
               run_in = '0;
            end
         endcase
      end
      rsp_changed_in = (gain_in != gain_ff);
   end

   // configuration registers; the initial gain only loads the gain state
   always_ff @(posedge clock) begin
      if (reset) begin
         min_gain_ff     <= '0;
         max_gain_ff     <= '1;
         decision_ff     <= agas_pkg::DECISION_RESET;
      end else if (csr_wr_en) begin
         unique case (agas_pkg::csr_index_type'(csr_index))
            agas_pkg::CSR_MIN_GAIN:        min_gain_ff     <= wr_gain;
            agas_pkg::CSR_MAX_GAIN:        max_gain_ff     <= wr_gain;
            agas_pkg::CSR_INITIAL_GAIN:    ;
            agas_pkg::CSR_DECISION_FRAMES: decision_ff     <= csr_wr_data[DB-1:0];
            default:                       ;
         endcase
      end
   end

   // controller state; an initial gain write reloads the gain
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= '0;
         verdict_ff <= agas_pkg::VERDICT_NORMAL;
         run_ff     <= '0;
      end else if (csr_wr_en &&
                   agas_pkg::csr_index_type'(csr_index) == agas_pkg::CSR_INITIAL_GAIN) begin
         gain_ff <= wr_clamped;
      end else if (accept) begin
         gain_ff    <= gain_in;
         verdict_ff <= verdict_in;
         run_ff     <= run_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_changed_ff <= rsp_changed_in;
         rsp_gain_ff    <= gain_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.gain_changed = rsp_changed_ff;
   assign rsp_ch.sensor_gain  = rsp_gain_ff;

   // checks
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result register not empty after reset");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item left no result");

   a_invalid_no_change: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_ch.ae_valid) |=> !rsp_changed_ff)
      else $error("invalid frame changed the gain");

   a_neutral_clears_run: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.ae_valid && !csr_wr_en &&
       (verdict == agas_pkg::VERDICT_NORMAL || verdict == agas_pkg::VERDICT_HOLD))
      |=> (run_ff == '0) && !rsp_changed_ff)
      else $error("normal or hold verdict did not clear the run");

   a_initial_bounds: assert property (@(posedge clock) disable iff (reset)
      (csr_wr_en && !accept &&
       agas_pkg::csr_index_type'(csr_index) == agas_pkg::CSR_INITIAL_GAIN)
      |=> (gain_ff >= min_gain_ff) && (gain_ff <= eff_max))
      else $error("initial gain load outside limits");

endmodule

`default_nettype wire
